>>> hdl/vau_pkg.sv
`default_nettype none

package vau_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 2;

    localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
    localparam int POS_WIDTH       = $clog2(DIFF_WIDTH);
    localparam int NORM_TOP        = 29;
    localparam int NORM_WIDTH      = NORM_TOP + 1;
    localparam int PROD_WIDTH      = 2 * NORM_WIDTH;
    localparam int SUM_WIDTH       = PROD_WIDTH + 1;

    localparam int ROOT_WIDTH      = 31;
    localparam int RAD_WIDTH       = 2 * ROOT_WIDTH;
    localparam int DIVIDEND_WIDTH  = 60;
    localparam int DIVISOR_WIDTH   = 31;
    localparam int QUOT_WIDTH      = 34;

    localparam int CORDIC_STEPS    = 32;
    localparam int CORDIC_WIDTH    = 44;
    localparam int CORDIC_PRESHIFT = 10;
    localparam int Z_WIDTH         = 36;

    localparam logic [ROOT_WIDTH-1:0] ONE_Q30 = ROOT_WIDTH'(64'd1 << 30);
    localparam logic [RAD_WIDTH-1:0]  ONE_Q60 = RAD_WIDTH'(64'd1 << 60);
    localparam logic [Z_WIDTH-1:0]    PI_Q32  = Z_WIDTH'(64'd13493037704);
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_PI = ANGLE_WIDTH'(
        (64'(PI_Q32) + (64'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS));

    // Arctangent of two to the minus i, in units of two to the minus 32 radians.
    function automatic logic [31:0] atan_q32(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'd3373259426;
            1:       v = 32'd1991351318;
            2:       v = 32'd1052175346;
            3:       v = 32'd534100635;
            4:       v = 32'd268086748;
            5:       v = 32'd134174063;
            6:       v = 32'd67103403;
            7:       v = 32'd33553749;
            8:       v = 32'd16777131;
            9:       v = 32'd8388597;
            10:      v = 32'd4194303;
            11:      v = 32'd2097152;
            default: v = 32'(64'd1 << (32 - i));
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hdl/vau_points_if.sv
`default_nettype none

interface vau_points_if;
    logic valid;
    logic ready;
    logic signed [vau_pkg::COORD_WIDTH-1:0] apex_x;
    logic signed [vau_pkg::COORD_WIDTH-1:0] apex_y;
    logic signed [vau_pkg::COORD_WIDTH-1:0] apex_z;
    logic signed [vau_pkg::COORD_WIDTH-1:0] first_x;
    logic signed [vau_pkg::COORD_WIDTH-1:0] first_y;
    logic signed [vau_pkg::COORD_WIDTH-1:0] first_z;
    logic signed [vau_pkg::COORD_WIDTH-1:0] second_x;
    logic signed [vau_pkg::COORD_WIDTH-1:0] second_y;
    logic signed [vau_pkg::COORD_WIDTH-1:0] second_z;

    modport source (
        output valid, apex_x, apex_y, apex_z, first_x, first_y, first_z,
        output second_x, second_y, second_z,
        input  ready
    );
    modport sink (
        input  valid, apex_x, apex_y, apex_z, first_x, first_y, first_z,
        input  second_x, second_y, second_z,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/vau_result_if.sv
`default_nettype none

interface vau_result_if;
    logic valid;
    logic ready;
    logic [vau_pkg::ANGLE_WIDTH-1:0] angle;
    logic degenerate;

    modport source (output valid, angle, degenerate, input ready);
    modport sink (input valid, angle, degenerate, output ready);
endinterface

`default_nettype wire

>>> hdl/vau_isqrt.sv
`default_nettype none

module vau_isqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           in_valid,
    input  logic [vau_pkg::RAD_WIDTH-1:0]  rad,
    output logic                           out_valid,
    output logic [vau_pkg::ROOT_WIDTH-1:0] root
);
    import vau_pkg::*;

    localparam int REM_WIDTH = ROOT_WIDTH + 3;

    typedef struct packed {
        logic [RAD_WIDTH-1:0]  rad;
        logic [REM_WIDTH-1:0]  rem;
        logic [ROOT_WIDTH-1:0] root;
    } sq_t;

    // One result bit per stage: the next pair of radicand bits joins the remainder.
    function automatic sq_t step(input sq_t s);
        sq_t o;
        logic [REM_WIDTH-1:0] cur;
        logic [REM_WIDTH-1:0] trial;
        cur   = {s.rem[REM_WIDTH-3:0], s.rad[RAD_WIDTH-1 -: 2]};
        trial = REM_WIDTH'({s.root, 2'b01});
        o.rad = s.rad << 2;
        if (cur >= trial)
        begin
            o.rem  = cur - trial;
            o.root = {s.root[ROOT_WIDTH-2:0], 1'b1};
        end
        else
        begin
            o.rem  = cur;
            o.root = {s.root[ROOT_WIDTH-2:0], 1'b0};
        end
        return o;
    endfunction

    sq_t  st_reg [ROOT_WIDTH];
    logic v_reg  [ROOT_WIDTH];
    sq_t  first;

    assign first = '{rad: rad, rem: '0, root: '0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ROOT_WIDTH; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < ROOT_WIDTH; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st_reg[0] <= step(first);
            for (int k = 1; k < ROOT_WIDTH; k++)
            begin
                st_reg[k] <= step(st_reg[k-1]);
            end
        end
    end

    assign out_valid = v_reg[ROOT_WIDTH-1];
    assign root      = st_reg[ROOT_WIDTH-1].root;

endmodule

`default_nettype wire

>>> hdl/vau_div.sv
`default_nettype none

module vau_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic                               in_valid,
    input  logic [vau_pkg::DIVIDEND_WIDTH-1:0] dividend,
    input  logic [vau_pkg::DIVISOR_WIDTH-1:0]  divisor,
    output logic                               out_valid,
    output logic [vau_pkg::QUOT_WIDTH-1:0]     quotient
);
    import vau_pkg::*;

    localparam int TRIAL_WIDTH = DIVISOR_WIDTH + QUOT_WIDTH;

    typedef struct packed {
        logic [DIVIDEND_WIDTH-1:0] rem;
        logic [DIVISOR_WIDTH-1:0]  dvs;
        logic [QUOT_WIDTH-1:0]     quot;
    } dv_t;

    function automatic dv_t step(input dv_t s, input int b);
        dv_t o;
        logic [TRIAL_WIDTH-1:0] trial;
        trial = TRIAL_WIDTH'(s.dvs) << b;
        o     = s;
        if (TRIAL_WIDTH'(s.rem) >= trial)
        begin
            o.rem     = s.rem - DIVIDEND_WIDTH'(trial);
            o.quot[b] = 1'b1;
        end
        return o;
    endfunction

    dv_t  st_reg [QUOT_WIDTH];
    logic v_reg  [QUOT_WIDTH];
    dv_t  first;

    assign first = '{rem: dividend, dvs: divisor, quot: '0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QUOT_WIDTH; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < QUOT_WIDTH; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st_reg[0] <= step(first, QUOT_WIDTH - 1);
            for (int k = 1; k < QUOT_WIDTH; k++)
            begin
                st_reg[k] <= step(st_reg[k-1], QUOT_WIDTH - 1 - k);
            end
        end
    end

    assign out_valid = v_reg[QUOT_WIDTH-1];
    assign quotient  = st_reg[QUOT_WIDTH-1].quot;

endmodule

`default_nettype wire

>>> hdl/vertex_angle_unit.sv
// Channel   Modport  Carries
// points    sink     apex, first and second neighbour coordinates
// result    source   angle at the apex, degenerate flag
//
// One item is taken every cycle unless a held result stalls the pipeline; each passes
// through two 31-stage square roots in series, a 34-stage divider, a 33-stage CORDIC
// including its start stage, and twelve single stages around them.
// Reset clears the valid bits of every stage; no item is in flight afterwards.
// When the result is not taken the whole pipeline holds, and points.ready falls.
`default_nettype none

module vertex_angle_unit (
    input  logic         clk,
    input  logic         rst_n,
    vau_points_if.sink   points,
    vau_result_if.source result
);
    import vau_pkg::*;

    localparam int SQRT_LAT = ROOT_WIDTH;
    localparam int DIV_LAT  = QUOT_WIDTH;

    typedef struct packed {
        logic signed [SUM_WIDTH-1:0] dot;
        logic                        deg;
    } side_dot_t;

    typedef struct packed {
        logic neg;
        logic deg;
    } side_div_t;

    typedef struct packed {
        logic [ROOT_WIDTH-1:0] cc;
        logic                  neg;
        logic                  deg;
    } side_sin_t;

    logic advance;
    logic out_valid_reg;
    logic [ANGLE_WIDTH-1:0] angle_reg;
    logic degenerate_reg;

    assign advance      = !out_valid_reg || result.ready;
    assign points.ready = advance;

    // Edge vectors.
    logic signed [COORD_WIDTH-1:0] apex [3];
    logic signed [COORD_WIDTH-1:0] nb   [2][3];
    logic signed [DIFF_WIDTH-1:0]  e_next [2][3];
    logic                          deg1_next;
    logic signed [DIFF_WIDTH-1:0]  e_reg [2][3];
    logic                          v1_reg, deg1_reg;

    always_comb
    begin
        apex[0]  = points.apex_x;
        apex[1]  = points.apex_y;
        apex[2]  = points.apex_z;
        nb[0][0] = points.first_x;
        nb[0][1] = points.first_y;
        nb[0][2] = points.first_z;
        nb[1][0] = points.second_x;
        nb[1][1] = points.second_y;
        nb[1][2] = points.second_z;
        for (int j = 0; j < 2; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e_next[j][i] = DIFF_WIDTH'(nb[j][i]) - DIFF_WIDTH'(apex[i]);
            end
        end
        deg1_next = (e_next[0][0] == 0 && e_next[0][1] == 0 && e_next[0][2] == 0) ||
                    (e_next[1][0] == 0 && e_next[1][1] == 0 && e_next[1][2] == 0);
    end

    // Magnitudes and their combined bit pattern.
    logic [DIFF_WIDTH-1:0] mag_next [2][3];
    logic [DIFF_WIDTH-1:0] mag_reg  [2][3];
    logic                  neg_reg  [2][3];
    logic [DIFF_WIDTH-1:0] orv_reg  [2];
    logic                  v2_reg, deg2_reg;

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_next[j][i] = e_reg[j][i][DIFF_WIDTH-1] ? DIFF_WIDTH'(-e_reg[j][i])
                                                           : DIFF_WIDTH'(e_reg[j][i]);
            end
        end
    end

    // Leading one of the largest magnitude.
    logic [POS_WIDTH-1:0]  pos_next [2];
    logic [POS_WIDTH-1:0]  pos_reg  [2];
    logic [DIFF_WIDTH-1:0] mag3_reg [2][3];
    logic                  neg3_reg [2][3];
    logic                  v3_reg, deg3_reg;

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            pos_next[j] = '0;
            for (int k = 0; k < DIFF_WIDTH; k++)
            begin
                if (orv_reg[j][k])
                begin
                    pos_next[j] = POS_WIDTH'(k);
                end
            end
        end
    end

    // Normalised vectors.
    logic [DIFF_WIDTH+NORM_TOP-1:0] wide [2][3];
    logic [DIFF_WIDTH+NORM_TOP-1:0] shifted [2][3];
    logic signed [NORM_WIDTH-1:0]   a_next [2][3];
    logic signed [NORM_WIDTH-1:0]   a_reg  [2][3];
    logic                           v4_reg, deg4_reg;

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                wide[j][i] = (DIFF_WIDTH+NORM_TOP)'(mag3_reg[j][i]);
                if (pos_reg[j] >= POS_WIDTH'(NORM_TOP - 1))
                begin
                    shifted[j][i] = wide[j][i] >> (pos_reg[j] - POS_WIDTH'(NORM_TOP - 1));
                end
                else
                begin
                    shifted[j][i] = wide[j][i] << (POS_WIDTH'(NORM_TOP - 1) - pos_reg[j]);
                end
                a_next[j][i] = neg3_reg[j][i]
                             ? -$signed({1'b0, shifted[j][i][NORM_TOP-1:0]})
                             : $signed({1'b0, shifted[j][i][NORM_TOP-1:0]});
            end
        end
    end

    // Products, then sums.
    logic signed [PROD_WIDTH-1:0] dp_reg [3];
    logic signed [PROD_WIDTH-1:0] sq_reg [2][3];
    logic                         v5_reg, deg5_reg;
    logic signed [SUM_WIDTH-1:0]  dot6_reg;
    logic [RAD_WIDTH-1:0]         rad6_reg [2];
    logic                         v6_reg, deg6_reg;

    // Edge lengths.
    logic                  n_valid;
    logic [ROOT_WIDTH-1:0] n0, n1;
    side_dot_t             sa_reg [SQRT_LAT];

    vau_isqrt u_len0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (v6_reg),
        .rad       (rad6_reg[0]),
        .out_valid (n_valid),
        .root      (n0)
    );

    vau_isqrt u_len1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (v6_reg),
        .rad       (rad6_reg[1]),
        .out_valid (),
        .root      (n1)
    );

    logic [RAD_WIDTH-1:0]         den7_reg;
    logic signed [SUM_WIDTH-1:0]  dot7_reg;
    logic                         v7_reg, deg7_reg;
    logic [DIVISOR_WIDTH-1:0]     dvs8_reg;
    logic [DIVIDEND_WIDTH-1:0]    dmag8_reg;
    logic                         v8_reg, deg8_reg, neg8_reg;

    // Cosine.
    logic                  q_valid;
    logic [QUOT_WIDTH-1:0] quot;
    side_div_t             sb_reg [DIV_LAT];

    vau_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (v8_reg),
        .dividend  (dmag8_reg),
        .divisor   (dvs8_reg),
        .out_valid (q_valid),
        .quotient  (quot)
    );

    logic [ROOT_WIDTH-1:0] cc9_reg, cc10_reg, cc11_reg;
    logic                  neg9_reg, neg10_reg, neg11_reg;
    logic                  deg9_reg, deg10_reg, deg11_reg;
    logic                  v9_reg, v10_reg, v11_reg;
    logic [RAD_WIDTH-1:0]  cc2_reg, rad11_reg;

    // Sine.
    logic                  s_valid;
    logic [ROOT_WIDTH-1:0] sine;
    side_sin_t             sc_reg [SQRT_LAT];

    vau_isqrt u_sine (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (v11_reg),
        .rad       (rad11_reg),
        .out_valid (s_valid),
        .root      (sine)
    );

    // CORDIC, entry zero holding the start vector.
    logic signed [CORDIC_WIDTH-1:0] cx_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_WIDTH-1:0] cy_reg [CORDIC_STEPS+1];
    logic signed [Z_WIDTH-1:0]      cz_reg [CORDIC_STEPS+1];
    logic                           cd_reg [CORDIC_STEPS+1];
    logic                           cv_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_WIDTH-1:0] cos_scaled, sin_scaled;
    logic [Z_WIDTH-1:0]             z_clamped;
    logic [Z_WIDTH-1:0]             z_rounded;

    assign cos_scaled = $signed(CORDIC_WIDTH'(sc_reg[SQRT_LAT-1].cc) << CORDIC_PRESHIFT);
    assign sin_scaled = $signed(CORDIC_WIDTH'(sine) << CORDIC_PRESHIFT);

    always_comb
    begin
        if (cz_reg[CORDIC_STEPS][Z_WIDTH-1])
        begin
            z_clamped = '0;
        end
        else if ($unsigned(cz_reg[CORDIC_STEPS]) > PI_Q32)
        begin
            z_clamped = PI_Q32;
        end
        else
        begin
            z_clamped = $unsigned(cz_reg[CORDIC_STEPS]);
        end
        z_rounded = (z_clamped + Z_WIDTH'(64'd1 << (31 - ANGLE_FRAC_BITS)))
                    >> (32 - ANGLE_FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            v10_reg       <= 1'b0;
            v11_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= CORDIC_STEPS; k++)
            begin
                cv_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            v1_reg    <= points.valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            v7_reg    <= n_valid;
            v8_reg    <= v7_reg;
            v9_reg    <= q_valid;
            v10_reg   <= v9_reg;
            v11_reg   <= v10_reg;
            cv_reg[0] <= s_valid;
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                cv_reg[k+1] <= cv_reg[k];
            end
            out_valid_reg <= cv_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            e_reg    <= e_next;
            deg1_reg <= deg1_next;

            mag_reg  <= mag_next;
            for (int j = 0; j < 2; j++)
            begin
                orv_reg[j] <= mag_next[j][0] | mag_next[j][1] | mag_next[j][2];
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[j][i] <= e_reg[j][i][DIFF_WIDTH-1];
                end
            end
            deg2_reg <= deg1_reg;

            pos_reg  <= pos_next;
            mag3_reg <= mag_reg;
            neg3_reg <= neg_reg;
            deg3_reg <= deg2_reg;

            a_reg    <= a_next;
            deg4_reg <= deg3_reg;

            for (int i = 0; i < 3; i++)
            begin
                dp_reg[i]    <= a_reg[0][i] * a_reg[1][i];
                sq_reg[0][i] <= a_reg[0][i] * a_reg[0][i];
                sq_reg[1][i] <= a_reg[1][i] * a_reg[1][i];
            end
            deg5_reg <= deg4_reg;

            dot6_reg <= SUM_WIDTH'(dp_reg[0]) + SUM_WIDTH'(dp_reg[1]) + SUM_WIDTH'(dp_reg[2]);
            for (int j = 0; j < 2; j++)
            begin
                rad6_reg[j] <= RAD_WIDTH'($unsigned(sq_reg[j][0]))
                             + RAD_WIDTH'($unsigned(sq_reg[j][1]))
                             + RAD_WIDTH'($unsigned(sq_reg[j][2]));
            end
            deg6_reg <= deg5_reg;

            sa_reg[0] <= '{dot: dot6_reg, deg: deg6_reg};
            for (int k = 1; k < SQRT_LAT; k++)
            begin
                sa_reg[k] <= sa_reg[k-1];
            end

            den7_reg <= n0 * n1;
            dot7_reg <= sa_reg[SQRT_LAT-1].dot;
            deg7_reg <= sa_reg[SQRT_LAT-1].deg;

            dvs8_reg  <= DIVISOR_WIDTH'((den7_reg + RAD_WIDTH'(64'd1 << 29)) >> 30);
            dmag8_reg <= dot7_reg[SUM_WIDTH-1] ? DIVIDEND_WIDTH'(-dot7_reg)
                                               : DIVIDEND_WIDTH'(dot7_reg);
            neg8_reg  <= dot7_reg[SUM_WIDTH-1];
            deg8_reg  <= deg7_reg;

            sb_reg[0] <= '{neg: neg8_reg, deg: deg8_reg};
            for (int k = 1; k < DIV_LAT; k++)
            begin
                sb_reg[k] <= sb_reg[k-1];
            end

            cc9_reg  <= (quot > QUOT_WIDTH'(ONE_Q30)) ? ONE_Q30 : quot[ROOT_WIDTH-1:0];
            // A cosine that truncates to zero is not negative.
            neg9_reg <= sb_reg[DIV_LAT-1].neg && (quot != '0);
            deg9_reg <= sb_reg[DIV_LAT-1].deg;

            cc2_reg   <= cc9_reg * cc9_reg;
            cc10_reg  <= cc9_reg;
            neg10_reg <= neg9_reg;
            deg10_reg <= deg9_reg;

            rad11_reg <= ONE_Q60 - cc2_reg;
            cc11_reg  <= cc10_reg;
            neg11_reg <= neg10_reg;
            deg11_reg <= deg10_reg;

            sc_reg[0] <= '{cc: cc11_reg, neg: neg11_reg, deg: deg11_reg};
            for (int k = 1; k < SQRT_LAT; k++)
            begin
                sc_reg[k] <= sc_reg[k-1];
            end

            // An obtuse angle starts turned by a quarter turn.
            if (sc_reg[SQRT_LAT-1].neg)
            begin
                cx_reg[0] <= sin_scaled;
                cy_reg[0] <= cos_scaled;
                cz_reg[0] <= $signed(Z_WIDTH'(atan_q32(0)) << 1);
            end
            else
            begin
                cx_reg[0] <= cos_scaled;
                cy_reg[0] <= sin_scaled;
                cz_reg[0] <= '0;
            end
            cd_reg[0] <= sc_reg[SQRT_LAT-1].deg;

            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                if (cy_reg[k] > 0)
                begin
                    cx_reg[k+1] <= cx_reg[k] + (cy_reg[k] >>> k);
                    cy_reg[k+1] <= cy_reg[k] - (cx_reg[k] >>> k);
                    cz_reg[k+1] <= cz_reg[k] + $signed(Z_WIDTH'(atan_q32(k)));
                end
                else
                begin
                    cx_reg[k+1] <= cx_reg[k] - (cy_reg[k] >>> k);
                    cy_reg[k+1] <= cy_reg[k] + (cx_reg[k] >>> k);
                    cz_reg[k+1] <= cz_reg[k] - $signed(Z_WIDTH'(atan_q32(k)));
                end
                cd_reg[k+1] <= cd_reg[k];
            end

            angle_reg      <= cd_reg[CORDIC_STEPS] ? '0 : z_rounded[ANGLE_WIDTH-1:0];
            degenerate_reg <= cd_reg[CORDIC_STEPS];
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.angle      = angle_reg;
    assign result.degenerate = degenerate_reg;

endmodule

`default_nettype wire

>>> hdl/vau_checker.sv
`default_nettype none

module vau_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            points_ready,
    input logic                            result_valid,
    input logic                            result_ready,
    input logic [vau_pkg::ANGLE_WIDTH-1:0] angle,
    input logic                            degenerate
);
    import vau_pkg::*;

    a_degenerate_zero : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && degenerate |-> angle == '0)
        else $error("degenerate item with a nonzero angle");

    a_angle_range : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> angle <= ANGLE_PI)
        else $error("angle beyond pi");

    a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> points_ready)
        else $error("input stalled with an empty output register");

    a_result_held : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(angle) && $stable(degenerate))
        else $error("stalled result changed");

    a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !points_ready)
        else $error("item taken while the pipeline is held");

endmodule

bind vertex_angle_unit vau_checker u_vau_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .points_ready (points.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .angle        (result.angle),
    .degenerate   (result.degenerate)
);

`default_nettype wire
